[rtl/bpl_pkg.sv]
// ----------------------------------------------------------------------------
// bpl_pkg: shared types and constants for the bounded positional list
// Request and result beats, the request kinds, and the cell-chain control types.
// ----------------------------------------------------------------------------
package bpl_pkg;

    localparam int DEPTH = 16;                                 // list capacity
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;    // cell index width
    localparam int CNT_W = $clog2(DEPTH + 1);                  // fill count width
    localparam int POS_W = 8;                                  // request position width
    localparam int LEN_W = 9;                                  // length / found width
    localparam int VAL_W = 32;                                 // entry width

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_GET    = 2'd2,
        REQ_LOCATE = 2'd3
    } t_req_kind;

    typedef struct packed {
        t_req_kind                 req_type;
        logic        [POS_W-1:0]   position;
        logic signed [VAL_W-1:0]   item_value;
    } t_req;

    typedef struct packed {
        logic                      ok;
        logic signed [VAL_W-1:0]   value_out;
        logic        [LEN_W-1:0]   found_position;
        logic        [LEN_W-1:0]   length_out;
    } t_res;

    // Broadcast to every cell in the cycle a request beat is taken.
    typedef struct packed {
        logic                      shift_up;   // valid insert
        logic                      shift_dn;   // valid delete
        logic        [LEN_W-1:0]   pos;        // 1-based position
        logic        [LEN_W-1:0]   cnt;        // fill count before the beat
        logic        [VAL_W-1:0]   value;      // insert data / locate key
    } t_cmd;

    // Passed from cell to cell along the chain.
    typedef struct packed {
        logic                      hit;        // an earlier cell matched the key
        logic        [LEN_W-1:0]   found;      // 1-based position of first match
        logic        [VAL_W-1:0]   rdata;      // entry at the addressed position
    } t_link;

endpackage

[rtl/bpl_cell.sv]
// ----------------------------------------------------------------------------
// bpl_cell: one slot of the list
// Holds one entry, shifts with its neighbours, compares against the key and
// merges its read data and match into the chain link.
// ----------------------------------------------------------------------------
module bpl_cell (
    input  logic                          i_clk,
    input  logic [bpl_pkg::IDX_W-1:0]     i_index,
    input  bpl_pkg::t_cmd                 i_cmd,
    input  logic [bpl_pkg::VAL_W-1:0]     i_left,
    input  logic [bpl_pkg::VAL_W-1:0]     i_right,
    input  bpl_pkg::t_link                i_link,
    output bpl_pkg::t_link                o_link,
    output logic [bpl_pkg::VAL_W-1:0]     o_entry
);
    import bpl_pkg::*;

    logic [VAL_W-1:0] r_entry;
    logic [VAL_W-1:0] n_entry;
    logic [LEN_W-1:0] w_slot;   // this cell's 1-based position
    logic             w_match;

    assign w_slot  = LEN_W'(i_index) + LEN_W'(1);
    assign w_match = (w_slot <= i_cmd.cnt) && (r_entry == i_cmd.value);

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.shift_up) begin
            if (w_slot > i_cmd.pos) begin
                n_entry = i_left;
            end else if (w_slot == i_cmd.pos) begin
                n_entry = i_cmd.value;
            end
        end else if (i_cmd.shift_dn) begin
            if ((w_slot >= i_cmd.pos) && (w_slot < i_cmd.cnt)) begin
                n_entry = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    always_comb begin
        o_link = i_link;
        if (!i_link.hit && w_match) begin
            o_link.hit   = 1'b1;
            o_link.found = w_slot;
        end
        if (w_slot == i_cmd.pos) begin
            o_link.rdata = r_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

[rtl/bounded_positional_list.sv]
// ----------------------------------------------------------------------------
// bounded_positional_list: fixed-capacity ordered list of signed words
// The result beat is on o_res, marked by o_strobe, in the cycle after
//   the request beat is taken; the receiver cannot stall it.
// Throughput: one request per cycle; busy stays low, as the cell chain shifts,
//   reads and compares for every request before its result beat is registered.
// Reset (synchronous, active low) empties the list and drops the strobe; the
//   entry registers are not cleared, as only filled positions are ever read.
// ----------------------------------------------------------------------------
module bounded_positional_list (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  bpl_pkg::t_req   i_req,
    output logic            o_strobe,
    output bpl_pkg::t_res   o_res
);
    import bpl_pkg::*;

    // Fill count and registered result beat.
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_strobe;
    t_res             r_res;
    t_res             n_res;

    logic             w_take;
    logic [LEN_W-1:0] w_cnt;
    logic [LEN_W-1:0] w_pos;
    logic             w_in_list;   // position in 1..count
    logic             w_ins_ok;
    logic             w_del_ok;
    logic             w_get_ok;
    t_cmd             w_cmd;

    // Chain wiring: link k enters cell k; cell k's entry feeds both neighbours.
    t_link            w_link  [DEPTH+1];
    logic [VAL_W-1:0] w_entry [DEPTH];

    // The block never holds start off: busy is tied low for every request.
    assign busy   = 1'b0;
    assign w_take = start && !busy;

    assign w_cnt     = LEN_W'(r_count);
    assign w_pos     = LEN_W'(i_req.position);
    assign w_in_list = (w_pos >= LEN_W'(1)) && (w_pos <= w_cnt);

    // Insert may also append just past the tail, but never into a full list.
    assign w_ins_ok = w_take && (i_req.req_type == REQ_INSERT)
                    && (w_pos >= LEN_W'(1)) && (w_pos <= w_cnt + LEN_W'(1))
                    && (w_cnt < LEN_W'(DEPTH));
    assign w_del_ok = w_take && (i_req.req_type == REQ_DELETE) && w_in_list;
    assign w_get_ok = (i_req.req_type == REQ_GET) && w_in_list;

    always_comb begin
        w_cmd          = '0;
        w_cmd.shift_up = w_ins_ok;
        w_cmd.shift_dn = w_del_ok;
        w_cmd.pos      = w_pos;
        w_cmd.cnt      = w_cnt;
        w_cmd.value    = i_req.item_value;
    end

    assign w_link[0] = '0;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [VAL_W-1:0] w_left;
        logic [VAL_W-1:0] w_right;

        // End cells never take from beyond the chain; their own entry fills in.
        assign w_left  = (k == 0)         ? w_entry[k] : w_entry[(k > 0) ? k - 1 : k];
        assign w_right = (k == DEPTH - 1) ? w_entry[k]
                                          : w_entry[(k < DEPTH - 1) ? k + 1 : k];

        bpl_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(k)),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .i_link  (w_link[k]),
            .o_link  (w_link[k+1]),
            .o_entry (w_entry[k])
        );
    end

    // Result beat and next fill count.
    always_comb begin
        n_count = r_count;
        n_res   = '0;
        case (i_req.req_type)
            REQ_INSERT: begin
                n_res.ok = w_ins_ok;
                if (w_ins_ok) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            REQ_DELETE: begin
                n_res.ok = w_del_ok;
                if (w_del_ok) begin
                    n_res.value_out = w_link[DEPTH].rdata;
                    n_count         = r_count - CNT_W'(1);
                end
            end
            REQ_GET: begin
                n_res.ok = w_get_ok;
                if (w_get_ok) begin
                    n_res.value_out = w_link[DEPTH].rdata;
                end
            end
            REQ_LOCATE: begin
                n_res.ok             = w_link[DEPTH].hit;
                n_res.found_position = w_link[DEPTH].found;
            end
            default: begin
                n_res = '0;
            end
        endcase
        n_res.length_out = LEN_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_take;
            if (w_take) begin
                r_count <= n_count;
            end
        end
    end

    // Payload register, no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_res <= n_res;
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule
